// ===== rtl/wrrmq_pkg.sv =====
package wrrmq_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned DataWidth     = 32;
  localparam int unsigned LevelW        = 2;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned WeightW       = 8;
  localparam int unsigned NumWeightRegs = 4;
  localparam int unsigned WregIdxW      = 2;
  localparam int unsigned CfgIdxW       = 3;

  // Weight after reset, and for levels that have no register
  localparam logic [WeightW-1:0] WeightDefault = 8'd1;

  // Action codes of an input item
  localparam logic ActEnqueue = 1'b0;
  localparam logic ActDequeue = 1'b1;

  // Status codes of a result item
  localparam logic [StatusW-1:0] StatusDone    = 2'd0;
  localparam logic [StatusW-1:0] StatusDropped = 2'd1;
  localparam logic [StatusW-1:0] StatusNothing = 2'd2;

  // Command kinds after classification in the front end
  typedef enum logic [1:0] {
    CmdEnqueue,
    CmdDequeue,
    CmdReject
  } cmd_op_e;

  typedef struct packed {
    logic                        action;
    logic signed [DataWidth-1:0] value;
    logic [LevelW-1:0]           level;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0]          status;
    logic signed [DataWidth-1:0] data_out;
    logic                        all_empty;
  } out_item_t;

  typedef struct packed {
    cmd_op_e                     op;
    logic signed [DataWidth-1:0] value;
    logic [LevelW-1:0]           level;
  } cmd_t;

endpackage

// ===== rtl/wrrmq_front.sv =====
module wrrmq_front #(
  parameter int unsigned NUM_LEVELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  wrrmq_pkg::in_item_t item_i,
  output logic                cmd_valid_o,
  output wrrmq_pkg::cmd_t     cmd_o
);

  wrrmq_pkg::cmd_t cmd_class;
  wrrmq_pkg::cmd_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;
  logic            pop;

  // Classify the incoming item: dequeue, enqueue, or enqueue to a missing level
  always_comb begin
    cmd_class.value = item_i.value;
    cmd_class.level = item_i.level;
    if (item_i.action == wrrmq_pkg::ActDequeue) begin
      cmd_class.op = wrrmq_pkg::CmdDequeue;
    end else if (32'(item_i.level) >= NUM_LEVELS) begin
      cmd_class.op = wrrmq_pkg::CmdReject;
    end else begin
      cmd_class.op = wrrmq_pkg::CmdEnqueue;
    end
  end

  // Two-entry command queue; the back end drains one entry a cycle
  assign busy        = (count_q == 2'd2);
  assign push        = start & ~busy;
  assign pop         = (count_q != 2'd0);
  assign cmd_valid_o = pop;
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  // Hold queue pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_class;
    end
  end

endmodule

// ===== rtl/wrrmq_sched.sv =====
module wrrmq_sched #(
  parameter int unsigned NUM_LEVELS = 4,
  localparam int unsigned LvlW      = $clog2(NUM_LEVELS)
) (
  input  logic [LvlW-1:0]               cur_i,
  input  logic [wrrmq_pkg::WeightW-1:0] served_i,
  input  logic [NUM_LEVELS-1:0]         fill_nz_i,
  input  logic [wrrmq_pkg::WeightW-1:0] weight_i [NUM_LEVELS],
  output logic                          found_o,
  output logic [LvlW-1:0]               grant_o,
  output logic [LvlW-1:0]               cur_o,
  output logic [wrrmq_pkg::WeightW-1:0] served_o
);

  logic                          first_hit;
  logic [wrrmq_pkg::WeightW-1:0] served_inc;

  // Search the levels from the current one onwards; only the current level
  // carries its running burst count, every later one starts afresh
  always_comb begin
    logic [LvlW:0]   sum;
    logic [LvlW-1:0] idx;
    logic            elig;
    found_o   = 1'b0;
    grant_o   = cur_i;
    first_hit = 1'b0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      sum = {1'b0, cur_i} + (LvlW + 1)'(k);
      if (sum >= (LvlW + 1)'(NUM_LEVELS)) begin
        sum = sum - (LvlW + 1)'(NUM_LEVELS);
      end
      idx  = sum[LvlW-1:0];
      elig = fill_nz_i[idx] &&
             ((k == 0) ? (served_i < weight_i[idx]) : (weight_i[idx] != '0));
      if (!found_o && elig) begin
        found_o   = 1'b1;
        grant_o   = idx;
        first_hit = (k == 0);
      end
    end
  end

  // Advance the burst; move on once the granted level has had its weight
  always_comb begin
    served_inc = (first_hit ? served_i : '0) + 1'b1;
    if (!found_o) begin
      cur_o    = cur_i;
      served_o = '0;
    end else if (served_inc >= weight_i[grant_o]) begin
      cur_o    = (grant_o == LvlW'(NUM_LEVELS - 1)) ? '0 : grant_o + 1'b1;
      served_o = '0;
    end else begin
      cur_o    = grant_o;
      served_o = served_inc;
    end
  end

endmodule

// ===== rtl/wrrmq_back.sv =====
module wrrmq_back #(
  parameter int unsigned NUM_LEVELS  = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cmd_valid_i,
  input  wrrmq_pkg::cmd_t                     cmd_i,
  input  logic                                cfg_valid_i,
  input  logic [wrrmq_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wrrmq_pkg::WeightW-1:0]       cfg_data_i,
  output logic                                done_o,
  output wrrmq_pkg::out_item_t                result_o
);

  localparam int unsigned LvlW     = $clog2(NUM_LEVELS);
  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AddrW    = LvlW + PtrW;
  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned WeightW  = wrrmq_pkg::WeightW;
  localparam int unsigned DataW    = wrrmq_pkg::DataWidth;

  logic [PtrW-1:0]    head_q [NUM_LEVELS];
  logic [PtrW-1:0]    tail_q [NUM_LEVELS];
  logic [FillW-1:0]   fill_q [NUM_LEVELS];
  logic [FillW-1:0]   fill_d [NUM_LEVELS];
  logic [LvlW-1:0]    cur_q, cur_d;
  logic [WeightW-1:0] served_q, served_d;
  logic [WeightW-1:0] weight_q [wrrmq_pkg::NumWeightRegs];
  logic [WeightW-1:0] weight [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] fill_nz;
  logic [NUM_LEVELS-1:0] fill_nz_d;

  logic signed [DataW-1:0] mem [MemDepth];
  logic signed [DataW-1:0] rd_data_q;

  logic                             done_q;
  logic [wrrmq_pkg::StatusW-1:0]    status_q, status_d;
  logic                             all_empty_q;
  logic                             read_q;

  logic            is_enq;
  logic            is_deq;
  logic [LvlW-1:0] enq_lvl;
  logic            full;
  logic            enq_ok;
  logic            deq_ok;
  logic            found;
  logic [LvlW-1:0] grant;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    ptr_inc = (ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Map weight registers onto levels; extra levels keep the default weight
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_weight
    if (g < wrrmq_pkg::NumWeightRegs) begin : g_reg
      assign weight[g] = weight_q[g];
    end else begin : g_fixed
      assign weight[g] = wrrmq_pkg::WeightDefault;
    end
    assign fill_nz[g]   = (fill_q[g] != '0);
    assign fill_nz_d[g] = (fill_d[g] != '0);
  end

  // Decode the command at the head of the queue
  assign is_enq  = cmd_valid_i && (cmd_i.op == wrrmq_pkg::CmdEnqueue);
  assign is_deq  = cmd_valid_i && (cmd_i.op == wrrmq_pkg::CmdDequeue);
  assign enq_lvl = LvlW'(cmd_i.level);
  assign full    = (fill_q[enq_lvl] == FillW'(QUEUE_DEPTH));
  assign enq_ok  = is_enq && !full;
  assign deq_ok  = is_deq && found;

  wrrmq_sched #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_sched (
    .cur_i     (cur_q),
    .served_i  (served_q),
    .fill_nz_i (fill_nz),
    .weight_i  (weight),
    .found_o   (found),
    .grant_o   (grant),
    .cur_o     (cur_d),
    .served_o  (served_d)
  );

  // Update fill counts for this command
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      fill_d[i] = fill_q[i]
                + FillW'(enq_ok && (enq_lvl == LvlW'(i)))
                - FillW'(deq_ok && (grant == LvlW'(i)));
    end
  end

  // Pick the result status
  always_comb begin
    case (cmd_i.op)
      wrrmq_pkg::CmdEnqueue: status_d = full ? wrrmq_pkg::StatusDropped
                                             : wrrmq_pkg::StatusDone;
      wrrmq_pkg::CmdDequeue: status_d = found ? wrrmq_pkg::StatusDone
                                              : wrrmq_pkg::StatusNothing;
      wrrmq_pkg::CmdReject:  status_d = wrrmq_pkg::StatusDropped;
      default:               status_d = wrrmq_pkg::StatusDropped;
    endcase
  end

  // Hold queue pointers, scheduler state and weights
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
      for (int i = 0; i < wrrmq_pkg::NumWeightRegs; i++) begin
        weight_q[i] <= wrrmq_pkg::WeightDefault;
      end
      cur_q    <= '0;
      served_q <= '0;
      done_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (enq_ok) begin
        tail_q[enq_lvl] <= ptr_inc(tail_q[enq_lvl]);
      end
      if (deq_ok) begin
        head_q[grant] <= ptr_inc(head_q[grant]);
      end
      if (is_deq) begin
        cur_q    <= cur_d;
        served_q <= served_d;
      end
      if (cfg_valid_i && (32'(cfg_index_i) < wrrmq_pkg::NumWeightRegs) &&
          (32'(cfg_index_i) < NUM_LEVELS)) begin
        weight_q[cfg_index_i[wrrmq_pkg::WregIdxW-1:0]] <= cfg_data_i;
      end
      done_q <= cmd_valid_i;
    end
  end

  // Write the store on enqueue, read the granted head on dequeue
  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      mem[{enq_lvl, tail_q[enq_lvl]}] <= cmd_i.value;
    end
    if (deq_ok) begin
      rd_data_q <= mem[{grant, head_q[grant]}];
    end
  end

  // Register the result fields
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      status_q    <= status_d;
      all_empty_q <= ~|fill_nz_d;
      read_q      <= deq_ok;
    end
  end

  assign done_o             = done_q;
  assign result_o.status    = status_q;
  assign result_o.data_out  = read_q ? rd_data_q : '0;
  assign result_o.all_empty = all_empty_q;

  // A reported all-empty matches the live fill counts
  a_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && all_empty_q) |-> (fill_nz == '0))
    else $error("all_empty reported while a level holds data");

  // A grant only ever goes to a level that holds data and has weight
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |-> (fill_nz[grant] && (weight[grant] != '0)))
    else $error("grant to an empty or zero-weight level");

  // A fruitless search leaves the pointer where it was and restarts the burst
  a_miss_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_deq && !found) |=> ((served_q == '0) && (cur_q == $past(cur_q))))
    else $error("scheduler state moved on a dequeue that found nothing");

  // A served dequeue is reported as done
  a_served_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_ok |=> (done_q && (status_q == wrrmq_pkg::StatusDone) && read_q))
    else $error("served dequeue not reported as done");

endmodule

// ===== rtl/weighted_round_robin_multiqueue.sv =====
// Each result passes the command queue, is registered and strobes on done_o.
// Throughput: one item per cycle; the back end drains the two-entry command
// queue every cycle, so busy rises only if that queue fills. Results cannot be
// stalled by the receiver. Reset clears queue pointers, fill counts, the level
// pointer and burst count, and sets every weight to 1; the value store is not
// cleared and needs no clearing pass.
module weighted_round_robin_multiqueue #(
  parameter int unsigned NUM_LEVELS  = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  wrrmq_pkg::in_item_t                 item_i,
  output logic                                done_o,
  output wrrmq_pkg::out_item_t                result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wrrmq_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [wrrmq_pkg::WeightW-1:0]       cfg_data_i
);

  logic            cmd_valid;
  wrrmq_pkg::cmd_t cmd;

  // Weights are plain registers and take a write in any cycle
  assign cfg_ready_o = 1'b1;

  wrrmq_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  wrrmq_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule
